[rtl/utw_pkg.sv]
package utw_pkg;

    localparam logic [7:0] QMARK = 8'h3F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN
    } utw_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic pop;
    } utw_cmd_t;

    typedef struct packed {
        logic enable;
        logic step_done;
        logic step_has_res;
        logic res_empty;
        logic res_one;
    } utw_sts_t;

    function automatic logic is_cont(input logic [7:0] b);
        logic r;
        r = (b[7:6] == 2'b10);
        return r;
    endfunction

    function automatic logic [7:0] map_cp(input logic [20:0] cp);
        logic [7:0] r;
        if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF)) begin
            r = cp[7:0];
        end else begin
            unique case (cp)
                21'h020AC: r = 8'h80;
                21'h0201A: r = 8'h82;
                21'h00192: r = 8'h83;
                21'h0201E: r = 8'h84;
                21'h02026: r = 8'h85;
                21'h02020: r = 8'h86;
                21'h02021: r = 8'h87;
                21'h002C6: r = 8'h88;
                21'h02030: r = 8'h89;
                21'h00160: r = 8'h8A;
                21'h02039: r = 8'h8B;
                21'h00152: r = 8'h8C;
                21'h0017D: r = 8'h8E;
                21'h02018: r = 8'h91;
                21'h02019: r = 8'h92;
                21'h0201C: r = 8'h93;
                21'h0201D: r = 8'h94;
                21'h02022: r = 8'h95;
                21'h02013: r = 8'h96;
                21'h02014: r = 8'h97;
                21'h002DC: r = 8'h98;
                21'h02122: r = 8'h99;
                21'h00161: r = 8'h9A;
                21'h0203A: r = 8'h9B;
                21'h00153: r = 8'h9C;
                21'h0017E: r = 8'h9E;
                21'h00178: r = 8'h9F;
                default:   r = QMARK;
            endcase
        end
        return r;
    endfunction

endpackage

[rtl/utw_ctrl.sv]
module utw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  utw_pkg::utw_sts_t sts,
    output utw_pkg::utw_cmd_t cmd
);
    import utw_pkg::*;

    utw_state_t state_reg;
    utw_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.enable ? ST_FEED : ST_DRAIN;
                end
            end
            ST_FEED: begin
                cmd.step = 1'b1;
                if (sts.step_done) begin
                    state_next = sts.step_has_res ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.pop = 1'b1;
                    if (sts.res_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_drain_has_res: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DRAIN |-> !sts.res_empty)
        else $error("drain with empty result buffer");

    a_load_enabled_feeds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE && s_tvalid && sts.enable |=> state_reg == ST_FEED)
        else $error("enabled beat not fed");

endmodule

[rtl/utw_dp.sv]
module utw_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  utw_pkg::utw_cmd_t cmd,
    output utw_pkg::utw_sts_t sts,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic              cfg_valid,
    input  logic              cfg_data,
    output logic [7:0]        out_byte,
    output logic              out_run_last,
    output logic              out_str_end
);
    import utw_pkg::*;

    logic [7:0] pb_reg [3];
    logic [7:0] pb_next [3];
    logic [1:0] pcnt_reg, pcnt_next;
    logic [1:0] pexp_reg, pexp_next;
    logic [7:0] q_reg [3];
    logic [7:0] q_next [3];
    logic [1:0] qcnt_reg, qcnt_next;
    logic       last_reg, last_next;
    logic [7:0] res_reg [4];
    logic [7:0] res_next [4];
    logic [2:0] rcnt_reg, rcnt_next;
    logic       en_reg;

    logic [7:0] s_pb [3];
    logic [1:0] s_pcnt, s_pexp;
    logic [7:0] s_q [3];
    logic [1:0] s_qcnt;
    logic [7:0] s_res [4];
    logic [2:0] s_rcnt;
    logic       emit_v;
    logic [7:0] emit_b;
    logic [7:0] cur;
    logic [7:0] c1, c2;
    logic [20:0] cp;
    logic       good;
    logic [2:0] replay_cnt;

    assign cur = q_reg[0];
    assign c1  = (pcnt_reg >= 2'd2) ? pb_reg[1] : cur;
    assign c2  = (pcnt_reg == 2'd3) ? pb_reg[2] : cur;
    assign replay_cnt = {1'b0, pcnt_reg} + {1'b0, qcnt_reg} - 3'd1;

    always_comb begin
        unique case (pexp_reg)
            2'd1: begin
                cp   = {10'd0, pb_reg[0][4:0], c1[5:0]};
                good = is_cont(c1);
            end
            2'd2: begin
                cp   = {5'd0, pb_reg[0][3:0], c1[5:0], c2[5:0]};
                good = is_cont(c1) && is_cont(c2);
            end
            2'd3: begin
                cp   = {pb_reg[0][2:0], c1[5:0], c2[5:0], cur[5:0]};
                good = is_cont(c1) && is_cont(c2) && is_cont(cur);
            end
            default: begin
                cp   = '0;
                good = 1'b0;
            end
        endcase
    end

    // one feed of the queue head
    always_comb begin
        s_pb   = pb_reg;
        s_pcnt = pcnt_reg;
        s_pexp = pexp_reg;
        s_q[0] = q_reg[1];
        s_q[1] = q_reg[2];
        s_q[2] = q_reg[2];
        s_qcnt = qcnt_reg - 2'd1;
        s_res  = res_reg;
        s_rcnt = rcnt_reg;
        emit_v = 1'b0;
        emit_b = QMARK;
        if (pcnt_reg == 2'd0) begin
            priority if (cur[7] == 1'b0) begin
                emit_v = 1'b1;
                emit_b = cur;
            end else if (cur[7:5] == 3'b110) begin
                s_pb[0] = cur;
                s_pcnt  = 2'd1;
                s_pexp  = 2'd1;
            end else if (cur[7:4] == 4'b1110) begin
                s_pb[0] = cur;
                s_pcnt  = 2'd1;
                s_pexp  = 2'd2;
            end else if (cur[7:3] == 5'b11110) begin
                s_pb[0] = cur;
                s_pcnt  = 2'd1;
                s_pexp  = 2'd3;
            end else begin
                emit_v = 1'b1;
            end
        end else if (pcnt_reg < pexp_reg && pcnt_reg < 2'd3) begin
            s_pb[pcnt_reg] = cur;
            s_pcnt         = pcnt_reg + 2'd1;
        end else begin
            s_pcnt = 2'd0;
            s_pexp = 2'd0;
            emit_v = 1'b1;
            if (good) begin
                emit_b = map_cp(cp);
            end else begin
                unique case (pcnt_reg)
                    2'd1: begin
                        s_q[0] = cur;
                        s_q[1] = q_reg[1];
                        s_q[2] = q_reg[2];
                    end
                    2'd2: begin
                        s_q[0] = pb_reg[1];
                        s_q[1] = cur;
                        s_q[2] = q_reg[1];
                    end
                    default: begin
                        s_q[0] = pb_reg[1];
                        s_q[1] = pb_reg[2];
                        s_q[2] = cur;
                    end
                endcase
                s_qcnt = replay_cnt[1:0];
            end
        end
        // truncated string at the end of the beat
        if (s_qcnt == 2'd0 && last_reg) begin
            if (s_pcnt != 2'd0) begin
                emit_v = 1'b1;
                emit_b = QMARK;
            end
            s_pcnt = 2'd0;
            s_pexp = 2'd0;
        end
        if (emit_v && rcnt_reg < 3'd4) begin
            s_res[rcnt_reg[1:0]] = emit_b;
            s_rcnt               = rcnt_reg + 3'd1;
        end
    end

    always_comb begin
        pb_next   = pb_reg;
        pcnt_next = pcnt_reg;
        pexp_next = pexp_reg;
        q_next    = q_reg;
        qcnt_next = qcnt_reg;
        last_next = last_reg;
        res_next  = res_reg;
        rcnt_next = rcnt_reg;
        priority if (cmd.load) begin
            last_next = in_last;
            if (en_reg) begin
                q_next[0] = in_byte;
                qcnt_next = 2'd1;
                rcnt_next = 3'd0;
            end else begin
                pcnt_next   = 2'd0;
                pexp_next   = 2'd0;
                qcnt_next   = 2'd0;
                res_next[0] = in_byte;
                rcnt_next   = 3'd1;
            end
        end else if (cmd.step) begin
            pb_next   = s_pb;
            pcnt_next = s_pcnt;
            pexp_next = s_pexp;
            q_next    = s_q;
            qcnt_next = s_qcnt;
            res_next  = s_res;
            rcnt_next = s_rcnt;
        end else if (cmd.pop) begin
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
            res_next[2] = res_reg[3];
            rcnt_next   = rcnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcnt_reg <= 2'd0;
            pexp_reg <= 2'd0;
            qcnt_reg <= 2'd0;
            rcnt_reg <= 3'd0;
            last_reg <= 1'b0;
            en_reg   <= 1'b1;
        end else begin
            pcnt_reg <= pcnt_next;
            pexp_reg <= pexp_next;
            qcnt_reg <= qcnt_next;
            rcnt_reg <= rcnt_next;
            last_reg <= last_next;
            if (cfg_valid) begin
                en_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pb_reg  <= pb_next;
        q_reg   <= q_next;
        res_reg <= res_next;
    end

    assign sts.enable       = en_reg;
    assign sts.step_done    = (s_qcnt == 2'd0);
    assign sts.step_has_res = (s_rcnt != 3'd0);
    assign sts.res_empty    = (rcnt_reg == 3'd0);
    assign sts.res_one      = (rcnt_reg == 3'd1);

    assign out_byte     = res_reg[0];
    assign out_run_last = (rcnt_reg == 3'd1);
    assign out_str_end  = (rcnt_reg == 3'd1) && last_reg;

    a_res_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rcnt_reg <= 3'd4)
        else $error("result buffer overrun");

    a_owed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, pcnt_reg} + {1'b0, qcnt_reg}) <= 3'd4)
        else $error("pending and replay bytes exceed four");

    a_pend_vs_exp: assert property (@(posedge aclk) disable iff (!aresetn)
        pcnt_reg != 2'd0 |-> pcnt_reg <= pexp_reg)
        else $error("pending count beyond sequence length");

endmodule

[rtl/utf8_to_windows1252_transcoder.sv]
// UTF-8 to Windows-1252 transcoder.
// Input beats on s_*: one UTF-8 byte each, s_tlast marking the final byte of
// a string. Result beats on m_*: Windows-1252 bytes; m_tlast marks the final
// result caused by an input beat, m_tuser the final result of the string.
// An input beat may cause no result (lead or inner byte of a sequence) or
// up to four results (malformed sequences replayed byte by byte).
// cfg_valid/cfg_data write transcode_enable; cfg_ready is always high and
// writes are expected only while the block is idle. With the enable low,
// bytes pass unchanged and buffered bytes are dropped.
// Flow: the controller takes a beat, then feeds bytes one at a time through
// the single decode step (extra feeds only for replayed bytes), then offers
// the result beats in turn. A pass-through byte skips the decode step, and a
// buffered lead ends after the decode step with no result beat. The controller
// handles one beat at a time.
// A stalled m_tready holds the result and s_tready stays low until every
// result of the current beat is taken. Reset (aresetn low, synchronous)
// clears the buffered sequence and sets the enable to 1.
module utf8_to_windows1252_transcoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic       m_tuser,   // [0] end_of_string
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import utw_pkg::*;

    utw_cmd_t cmd;
    utw_sts_t sts;

    assign cfg_ready = 1'b1;

    utw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    utw_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .in_byte      (s_tdata),
        .in_last      (s_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .out_byte     (m_tdata),
        .out_run_last (m_tlast),
        .out_str_end  (m_tuser)
    );

endmodule

[verif/utf8_to_windows1252_transcoder_tb.sv]
`timescale 1ns / 100ps

module utf8_to_windows1252_transcoder_tb;
    import utw_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       str_end;
    } cp1252_beat_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;   // [7:0] in_byte
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;             // [7:0] out_byte
    logic       m_tlast;
    logic       m_tuser;             // [0] end_of_string
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    logic [15:0] typo_cp [0:26] = '{
        16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D, 16'h2018,
        16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h02DC,
        16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h017E, 16'h0178
    };
    logic [7:0] typo_byte [0:26] = '{
        8'h80, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
        8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8E, 8'h91,
        8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98,
        8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9E, 8'h9F
    };

    logic [7:0]   held_bytes [0:2];
    logic [1:0]   held_count;
    logic [1:0]   held_need;
    logic         xcode_enable;
    cp1252_beat_t cp1252_beats_q [$];
    logic [7:0]   string_q [$];
    int           mismatch_count = 0;
    int           src_idle_pct   = 0;
    int           sink_idle_pct  = 0;

    utf8_to_windows1252_transcoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void clear_held();
        held_count    = 2'd0;
        held_need     = 2'd0;
        held_bytes[0] = 8'h00;
        held_bytes[1] = 8'h00;
        held_bytes[2] = 8'h00;
    endfunction

    function automatic logic [7:0] cp_to_cp1252(input logic [20:0] cp);
        int i;
        if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF)) begin
            return cp[7:0];
        end
        for (i = 0; i < 27; i++) begin
            if (cp == {5'b0, typo_cp[i]}) begin
                return typo_byte[i];
            end
        end
        return QMARK;
    endfunction

    // Replayed bytes go to the front of the work list, which keeps the
    // depth-first order of nested replays.
    function automatic void transcode_byte(input logic [7:0] b, input logic last);
        logic [7:0]   outs [$];
        logic [7:0]   work [$];
        logic [7:0]   seq [0:3];
        logic [7:0]   x;
        logic [20:0]  cp;
        logic         good;
        int           n;
        int           i;
        cp1252_beat_t bt;
        if (!xcode_enable) begin
            clear_held();
            outs = {outs, b};
        end else begin
            work = {work, b};
            while (work.size() > 0) begin
                x = work.pop_front();
                if (held_count == 2'd0) begin
                    if (!x[7]) begin
                        outs = {outs, x};
                    end else if (x[7:5] == 3'b110) begin
                        held_bytes[0] = x; held_count = 2'd1; held_need = 2'd1;
                    end else if (x[7:4] == 4'b1110) begin
                        held_bytes[0] = x; held_count = 2'd1; held_need = 2'd2;
                    end else if (x[7:3] == 5'b11110) begin
                        held_bytes[0] = x; held_count = 2'd1; held_need = 2'd3;
                    end else begin
                        outs = {outs, QMARK};
                    end
                end else if (held_count < held_need) begin
                    held_bytes[held_count] = x;
                    held_count = held_count + 2'd1;
                end else begin
                    n = held_count + 1;
                    for (i = 0; i < n - 1; i++) begin
                        seq[i] = held_bytes[i];
                    end
                    seq[n - 1] = x;
                    if (held_need == 2'd1) begin
                        cp = {16'b0, seq[0][4:0]};
                    end else if (held_need == 2'd2) begin
                        cp = {17'b0, seq[0][3:0]};
                    end else begin
                        cp = {18'b0, seq[0][2:0]};
                    end
                    good = 1'b1;
                    for (i = 1; i < n; i++) begin
                        if (good) begin
                            if (seq[i][7:6] != 2'b10) begin
                                good = 1'b0;
                            end else begin
                                cp = {cp[14:0], seq[i][5:0]};
                            end
                        end
                    end
                    clear_held();
                    if (good) begin
                        outs = {outs, cp_to_cp1252(cp)};
                    end else begin
                        outs = {outs, QMARK};
                        for (i = n - 1; i >= 1; i--) begin
                            work.push_front(seq[i]);
                        end
                    end
                end
            end
            if (last && held_count != 2'd0) begin
                outs = {outs, QMARK};
            end
            if (last) begin
                clear_held();
            end
        end
        while (outs.size() > 4) begin
            void'(outs.pop_back());
        end
        for (i = 0; i < outs.size(); i++) begin
            bt.data    = outs[i];
            bt.run_end = (i == outs.size() - 1);
            bt.str_end = (i == outs.size() - 1) && last;
            cp1252_beats_q = {cp1252_beats_q, bt};
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 40) begin
            $display("mismatch %s: got %02h, want %02h", what, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        cp1252_beat_t want;
        if (!aresetn) begin
            xcode_enable = 1'b1;
            clear_held();
            cp1252_beats_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                xcode_enable = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                transcode_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (cp1252_beats_q.size() == 0) begin
                    report_mismatch("unexpected beat, data", int'(m_tdata), 0);
                end else begin
                    want = cp1252_beats_q.pop_front();
                    if (m_tdata !== want.data) begin
                        report_mismatch("out_byte", int'(m_tdata), int'(want.data));
                    end
                    if (m_tlast !== want.run_end) begin
                        report_mismatch("last_of_run", int'(m_tlast), int'(want.run_end));
                    end
                    if (m_tuser !== want.str_end) begin
                        report_mismatch("end_of_string", int'(m_tuser),
                                        int'(want.str_end));
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_tready = aresetn && ($urandom_range(0, 99) >= sink_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = b;
        s_tlast  = last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_string();
        int i;
        for (i = 0; i < string_q.size(); i++) begin
            send_byte(string_q[i], i == string_q.size() - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (cp1252_beats_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_enable(input logic value);
        wait_drained();
        @(negedge aclk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic void append_byte(input logic [7:0] b);
        string_q = {string_q, b};
    endfunction

    function automatic void push_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            append_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
        end else begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
        end
    endfunction

    // Lead plus continuations with random content; one continuation
    // spoilt when broken is set.
    function automatic void push_raw_seq(input int extra, input logic broken);
        logic [7:0] b;
        int         bad_pos;
        int         i;
        if (extra == 1) begin
            b = 8'($urandom_range(8'hC0, 8'hDF));
        end else if (extra == 2) begin
            b = 8'($urandom_range(8'hE0, 8'hEF));
        end else begin
            b = 8'($urandom_range(8'hF0, 8'hF7));
        end
        append_byte(b);
        bad_pos = broken ? $urandom_range(1, extra) : 0;
        for (i = 1; i <= extra; i++) begin
            if (i == bad_pos) begin
                b = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7F))
                                         : 8'($urandom_range(8'hC0, 8'hFF));
            end else begin
                b = 8'($urandom_range(8'h80, 8'hBF));
            end
            append_byte(b);
        end
    endfunction

    function automatic void push_random_char();
        int         kind;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            b = 8'($urandom_range(0, 8'h7F));
            append_byte(b);
        end else if (kind < 45) begin
            push_utf8(21'($urandom_range(21'hA0, 21'hFF)));
        end else if (kind < 60) begin
            push_utf8({5'b0, typo_cp[$urandom_range(0, 26)]});
        end else if (kind < 85) begin
            push_raw_seq($urandom_range(1, 3), 1'b0);
        end else if (kind < 93) begin
            push_raw_seq($urandom_range(1, 3), 1'b1);
        end else begin
            b = 8'($urandom_range(0, 255));
            append_byte(b);
        end
    endfunction

    task automatic test_directed_sequences();
        string_q = '{8'h00};
        send_string();
        string_q = '{8'h7F, 8'hC3, 8'hBF, 8'hC2, 8'h80, 8'hC0, 8'h80};
        send_string();
        string_q = '{8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
        send_string();
        string_q = '{8'h80, 8'hFF, 8'hF0, 8'h41, 8'h42, 8'h43};
        send_string();
        string_q = '{8'hE2, 8'h41};
        send_string();
        string_q = '{8'hC3};
        send_string();
    endtask

    task automatic test_passthrough();
        send_byte(8'hE2, 1'b0);
        write_enable(1'b0);
        string_q = '{8'hC3, 8'hA9, 8'h80, 8'hFF, 8'h00, 8'h7F};
        send_string();
        write_enable(1'b1);
        string_q = '{8'hA9, 8'h41};
        send_string();
    endtask

    task automatic test_drain_pause();
        int k;
        for (k = 0; k < 3; k++) begin
            string_q.delete();
            push_random_char();
            push_random_char();
            send_string();
            wait_drained();
        end
    endtask

    task automatic test_random_strings(input int n_items);
        int sent;
        int n_chars;
        int i;
        sent = 0;
        while (sent < n_items) begin
            string_q.delete();
            n_chars = $urandom_range(1, 10);
            for (i = 0; i < n_chars; i++) begin
                push_random_char();
            end
            if ($urandom_range(0, 9) == 0) begin
                push_raw_seq($urandom_range(1, 3), 1'b0);
                for (i = $urandom_range(1, 3); i > 0 && string_q.size() > 1; i--) begin
                    void'(string_q.pop_back());
                end
            end
            send_string();
            sent += string_q.size();
        end
    endtask

    task automatic test_random_passthrough(input int n_items);
        int i;
        for (i = 0; i < n_items; i++) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        src_idle_pct  = 17;
        sink_idle_pct = 52;
        write_enable(1'b1);
        test_directed_sequences();
        test_passthrough();
        test_random_strings(70);
        test_drain_pause();
        src_idle_pct  = 52;
        sink_idle_pct = 17;
        write_enable(1'b0);
        test_random_passthrough(30);
        write_enable(1'b1);
        test_random_strings(50);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_strings(50);
        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/utw_pkg.sv
rtl/utw_ctrl.sv
rtl/utw_dp.sv
rtl/utf8_to_windows1252_transcoder.sv
verif/utf8_to_windows1252_transcoder_tb.sv
